// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the dispatch core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed under reset gating");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/efsd_pkg.sv =====
package efsd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned GAP_W  = 16;
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned OIDX_W = 3;

    localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [CFG_W-1:0]  SERVERS_RST  = 4'd8;

    typedef struct packed {
        logic [GAP_W-1:0] arrival_gap;
        logic [GAP_W-1:0] service_time;
    } t_in_item;

    typedef struct packed {
        logic [OIDX_W-1:0] server_index;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] depart_time;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] server_idle_total;
        logic [TIME_W-1:0] total_wait;
        logic              saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_ADD_SAT,
        ALU_SUB,
        ALU_LT
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic              lt;
    } t_alu_rsp;

    typedef struct packed {
        logic              we;
        logic [TIME_W-1:0] free_time;
        logic [TIME_W-1:0] idle_total;
    } t_file_wr;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ARRIVE,
        ST_START,
        ST_DEPART,
        ST_WAIT,
        ST_GAP,
        ST_IDLE_ACC,
        ST_TOTAL
    } t_state;

endpackage

// ===== hw/rtl/efsd_alu.sv =====
// One 33-bit adder serves saturating add, subtract and less-than.
module efsd_alu (
    input  efsd_pkg::t_alu_req i_req,
    output efsd_pkg::t_alu_rsp o_rsp
);

    logic                        w_inv;
    logic [efsd_pkg::TIME_W-1:0] w_b;
    logic [efsd_pkg::TIME_W:0]   w_sum;

    assign w_inv = (i_req.op != efsd_pkg::ALU_ADD_SAT);
    assign w_b   = w_inv ? ~i_req.b : i_req.b;
    assign w_sum = {1'b0, i_req.a} + {1'b0, w_b} + {{efsd_pkg::TIME_W{1'b0}}, w_inv};

    always_comb begin
        o_rsp.lt = ~w_sum[efsd_pkg::TIME_W];
        case (i_req.op)
            efsd_pkg::ALU_ADD_SAT: begin
                o_rsp.res = w_sum[efsd_pkg::TIME_W] ? efsd_pkg::TIME_MAX
                                                    : w_sum[efsd_pkg::TIME_W-1:0];
            end
            default: begin
                o_rsp.res = w_sum[efsd_pkg::TIME_W-1:0];
            end
        endcase
    end

endmodule

// ===== hw/rtl/efsd_server_file.sv =====
// Per-server free time and idle total, one registered read port and one write port.
module efsd_server_file #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned IW    = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [IW-1:0]               i_rd_idx,
    input  logic [IW-1:0]               i_wr_idx,
    input  efsd_pkg::t_file_wr          i_wr,
    output logic [efsd_pkg::TIME_W-1:0] o_rd_free,
    output logic [efsd_pkg::TIME_W-1:0] o_rd_idle
);

    logic [efsd_pkg::TIME_W-1:0] r_free [DEPTH];
    logic [efsd_pkg::TIME_W-1:0] r_idle [DEPTH];
    logic [efsd_pkg::TIME_W-1:0] r_rd_free;
    logic [efsd_pkg::TIME_W-1:0] r_rd_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_free[i] <= '0;
                r_idle[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_free[i_wr_idx] <= i_wr.free_time;
            r_idle[i_wr_idx] <= i_wr.idle_total;
        end
    end

    // Read data for i_rd_idx is registered and shows up in the next cycle.
    always_ff @(posedge i_clk) begin
        r_rd_free <= r_free[i_rd_idx];
        r_rd_idle <= r_idle[i_rd_idx];
    end

    assign o_rd_free = r_rd_free;
    assign o_rd_idle = r_rd_idle;

endmodule

// ===== hw/rtl/earliest_free_server_dispatch_core.sv =====
// Earliest-free server dispatch. Each input transfer is one job (arrival gap,
// service time); the block advances its arrival clock, picks the active server
// with the earliest free time (lowest index on ties), starts the job at the
// later of arrival and that free time, and returns one result transfer with
// the chosen server, arrival, start, departure, wait, the server's idle total,
// the running wait sum and a saturation flag. All times saturate at all-ones.
// The scan reads each active server's free time in turn (count clamped to
// 1..MAX_SERVERS), then seven steps run through the single shared add/compare
// unit. No new input transfer is taken until the result is loaded into the
// output register and the block is back in idle. The server file has a
// registered read port, so each read address is issued in the cycle before its
// data is used. The result sits in an output register; if it is not yet taken
// when the next result is ready, the sequencer holds in its last step. The
// user must write servers_in_use through i_cfg_we/i_cfg_wdata only while idle;
// the block itself does not enforce it. It resets to 8; a value of 0 acts as 1.
`include "assert_macros.svh"

module earliest_free_server_dispatch_core #(
    parameter int unsigned MAX_SERVERS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [efsd_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  efsd_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output efsd_pkg::t_out_item              o_out_data
);

    localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int unsigned NW = efsd_pkg::CFG_W + 1;

    efsd_pkg::t_state r_state, n_state;

    logic [efsd_pkg::GAP_W-1:0]  r_gap, r_svc;
    logic [IW-1:0]               r_idx, n_idx;
    logic [IW-1:0]               r_best, n_best;
    logic [efsd_pkg::TIME_W-1:0] r_best_free, n_best_free;
    logic [efsd_pkg::TIME_W-1:0] r_arrival, n_arrival;
    logic [efsd_pkg::TIME_W-1:0] r_start, n_start;
    logic [efsd_pkg::TIME_W-1:0] r_depart, n_depart;
    logic [efsd_pkg::TIME_W-1:0] r_wait, n_wait;
    logic [efsd_pkg::TIME_W-1:0] r_tmp, n_tmp;
    logic [efsd_pkg::TIME_W-1:0] r_wait_sum, n_wait_sum;
    logic [efsd_pkg::CFG_W-1:0]  r_servers;
    efsd_pkg::t_out_item         r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic [NW-1:0]               w_cnt;
    logic [IW-1:0]               w_last;
    logic                        w_in_xfer;
    logic                        w_out_load;
    logic [IW-1:0]               w_rd_idx;
    efsd_pkg::t_file_wr          w_wr;
    efsd_pkg::t_alu_req          w_alu_req;
    efsd_pkg::t_alu_rsp          w_alu_rsp;
    logic [efsd_pkg::TIME_W-1:0] w_rd_free, w_rd_idle;
    logic                        w_wait_ok;
    logic                        w_order_ok;

    assign o_in_ready  = (r_state == efsd_pkg::ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Clamp the active server count to 1..MAX_SERVERS; scan runs 0..w_last.
    always_comb begin
        w_cnt = {1'b0, r_servers};
        if (w_cnt == '0) begin
            w_cnt = NW'(1);
        end
        if (w_cnt > NW'(MAX_SERVERS)) begin
            w_cnt = NW'(MAX_SERVERS);
        end
        w_last = IW'(w_cnt - NW'(1));
    end

    // Result can go out once the output register is empty or draining now.
    assign w_out_load = (r_state == efsd_pkg::ST_TOTAL) && (!r_out_valid || i_out_ready);

    efsd_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    efsd_server_file #(
        .DEPTH (MAX_SERVERS),
        .IW    (IW)
    ) u_file (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (w_rd_idx),
        .i_wr_idx  (r_best),
        .i_wr      (w_wr),
        .o_rd_free (w_rd_free),
        .o_rd_idle (w_rd_idle)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            efsd_pkg::ST_IDLE:     if (w_in_xfer) n_state = efsd_pkg::ST_SCAN;
            efsd_pkg::ST_SCAN:     if (r_idx == w_last) n_state = efsd_pkg::ST_ARRIVE;
            efsd_pkg::ST_ARRIVE:   n_state = efsd_pkg::ST_START;
            efsd_pkg::ST_START:    n_state = efsd_pkg::ST_DEPART;
            efsd_pkg::ST_DEPART:   n_state = efsd_pkg::ST_WAIT;
            efsd_pkg::ST_WAIT:     n_state = efsd_pkg::ST_GAP;
            efsd_pkg::ST_GAP:      n_state = efsd_pkg::ST_IDLE_ACC;
            efsd_pkg::ST_IDLE_ACC: n_state = efsd_pkg::ST_TOTAL;
            efsd_pkg::ST_TOTAL:    if (w_out_load) n_state = efsd_pkg::ST_IDLE;
            default:               n_state = efsd_pkg::ST_IDLE;
        endcase
    end

    // Datapath control: drive the shared unit and form next register values.
    always_comb begin
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_free = r_best_free;
        n_arrival   = r_arrival;
        n_start     = r_start;
        n_depart    = r_depart;
        n_wait      = r_wait;
        n_tmp       = r_tmp;
        n_wait_sum  = r_wait_sum;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        // Outside the scan, keep reading the chosen server so that its idle
        // total is ready by the accumulate step.
        w_rd_idx    = r_best;
        w_wr        = '0;
        w_alu_req   = '{op: efsd_pkg::ALU_LT, a: w_rd_free, b: r_best_free};
        case (r_state)
            efsd_pkg::ST_IDLE: begin
                // Issue the read of server 0 so it is ready in the first scan cycle.
                n_idx    = '0;
                w_rd_idx = '0;
            end
            efsd_pkg::ST_SCAN: begin
                // Take server 0 outright; afterwards only a strictly earlier one.
                if (r_idx == '0 || w_alu_rsp.lt) begin
                    n_best      = r_idx;
                    n_best_free = w_rd_free;
                end
                n_idx    = r_idx + IW'(1);
                w_rd_idx = (r_idx == w_last) ? r_idx : r_idx + IW'(1);
            end
            efsd_pkg::ST_ARRIVE: begin
                w_alu_req = '{op: efsd_pkg::ALU_ADD_SAT, a: r_arrival,
                              b: {{(efsd_pkg::TIME_W-efsd_pkg::GAP_W){1'b0}}, r_gap}};
                n_arrival = w_alu_rsp.res;
            end
            efsd_pkg::ST_START: begin
                w_alu_req = '{op: efsd_pkg::ALU_LT, a: r_arrival, b: r_best_free};
                n_start   = w_alu_rsp.lt ? r_best_free : r_arrival;
            end
            efsd_pkg::ST_DEPART: begin
                w_alu_req = '{op: efsd_pkg::ALU_ADD_SAT, a: r_start,
                              b: {{(efsd_pkg::TIME_W-efsd_pkg::GAP_W){1'b0}}, r_svc}};
                n_depart  = w_alu_rsp.res;
            end
            efsd_pkg::ST_WAIT: begin
                w_alu_req = '{op: efsd_pkg::ALU_SUB, a: r_start, b: r_arrival};
                n_wait    = w_alu_rsp.res;
            end
            efsd_pkg::ST_GAP: begin
                w_alu_req = '{op: efsd_pkg::ALU_SUB, a: r_start, b: r_best_free};
                n_tmp     = w_alu_rsp.res;
            end
            efsd_pkg::ST_IDLE_ACC: begin
                // Fold the idle gap into the chosen server and retire its job.
                w_alu_req = '{op: efsd_pkg::ALU_ADD_SAT, a: w_rd_idle, b: r_tmp};
                n_tmp     = w_alu_rsp.res;
                w_wr      = '{we: 1'b1, free_time: r_depart, idle_total: w_alu_rsp.res};
            end
            efsd_pkg::ST_TOTAL: begin
                w_alu_req = '{op: efsd_pkg::ALU_ADD_SAT, a: r_wait_sum, b: r_wait};
                if (w_out_load) begin
                    n_wait_sum  = w_alu_rsp.res;
                    n_out_valid = 1'b1;
                    n_out.server_index      = efsd_pkg::OIDX_W'(r_best);
                    n_out.arrival_time      = r_arrival;
                    n_out.start_time        = r_start;
                    n_out.depart_time       = r_depart;
                    n_out.wait_time         = r_wait;
                    n_out.server_idle_total = r_tmp;
                    n_out.total_wait        = w_alu_rsp.res;
                    n_out.saturated = (r_arrival == efsd_pkg::TIME_MAX) ||
                                      (r_start == efsd_pkg::TIME_MAX) ||
                                      (r_depart == efsd_pkg::TIME_MAX) ||
                                      (r_tmp == efsd_pkg::TIME_MAX) ||
                                      (w_alu_rsp.res == efsd_pkg::TIME_MAX);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= efsd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_arrival   <= '0;
            r_wait_sum  <= '0;
            r_servers   <= efsd_pkg::SERVERS_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_arrival   <= n_arrival;
            r_wait_sum  <= n_wait_sum;
            if (i_cfg_we) begin
                r_servers <= i_cfg_wdata;
            end
        end
    end

    // Payload and working registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_gap <= i_in_data.arrival_gap;
            r_svc <= i_in_data.service_time;
        end
        r_idx       <= n_idx;
        r_best      <= n_best;
        r_best_free <= n_best_free;
        r_start     <= n_start;
        r_depart    <= n_depart;
        r_wait      <= n_wait;
        r_tmp       <= n_tmp;
        r_out       <= n_out;
    end

    assign w_wait_ok  = (r_out.wait_time == r_out.start_time - r_out.arrival_time);
    assign w_order_ok = (r_out.depart_time >= r_out.start_time);

    `ASSERT_RST(a_xfer_starts_scan, i_clk, i_rst_n, w_in_xfer |=> (r_state == efsd_pkg::ST_SCAN))
    `ASSERT_RST(a_best_in_range, i_clk, i_rst_n, (r_state == efsd_pkg::ST_TOTAL) |-> (r_best <= w_last))
    `ASSERT_RST(a_wait_matches, i_clk, i_rst_n, $rose(o_out_valid) |-> w_wait_ok)
    `ASSERT_RST(a_depart_after_start, i_clk, i_rst_n, $rose(o_out_valid) |-> w_order_ok)

endmodule
